[src/sed_pkg.sv]
package sed_pkg;

  localparam int CntW = 12;

  // escape mode, one-hot
  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_SLASH = 5'b00010,
    MODE_HEX1  = 5'b00100,
    MODE_HEX2  = 5'b01000,
    MODE_DROP  = 5'b10000
  } mode_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TRAIL    = 3'd1;
  localparam logic [2:0] ST_TRUNC    = 3'd2;
  localparam logic [2:0] ST_BADHEX   = 3'd3;
  localparam logic [2:0] ST_UNKNOWN  = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef struct packed {
    logic            vld;
    logic [7:0]      data;
    logic            has_byte;
    logic            eos;
    logic [2:0]      status;
    logic [CntW-1:0] count;
  } res_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - "0")};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end
    return r;
  endfunction

  // {valid, byte} for a one-letter escape
  function automatic logic [8:0] letter_val(input logic [7:0] c);
    logic [8:0] r;
    r = '0;
    case (c) inside
      "n", "N": r = {1'b1, 8'h0A};
      "r", "R": r = {1'b1, 8'h0D};
      "s", "S": r = {1'b1, 8'h20};
      "t", "T": r = {1'b1, 8'h09};
      "m", "M": r = {1'b1, ">"};
      "h", "H": r = {1'b1, "<"};
      "q", "Q": r = {1'b1, "?"};
      "a", "A": r = {1'b1, "*"};
      "d", "D": r = {1'b1, "$"};
      "p", "P": r = {1'b1, "|"};
      "=":      r = {1'b1, "~"};
      "/":      r = {1'b1, "/"};
      "0":      r = {1'b1, 8'h00};
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

[src/sed_step.sv]
module sed_step #(
  parameter int MAX_LEN = 2048
) (
  input  sed_pkg::mode_t             mode,
  input  logic [3:0]                 nib,
  input  logic [sed_pkg::CntW-1:0]   cnt,
  input  logic [7:0]                 in_char,
  input  logic                       in_fin,
  output sed_pkg::mode_t             mode_nxt,
  output logic [3:0]                 nib_nxt,
  output logic [sed_pkg::CntW-1:0]   cnt_nxt,
  output sed_pkg::res_t              res
);
  import sed_pkg::*;

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_LEN);

  logic       do_emit;
  logic [7:0] emit_val;
  logic       do_err;
  logic [2:0] err_st;
  logic       ovf;
  logic [4:0] hv;
  logic [8:0] lv;

  assign hv  = hex_val(in_char);
  assign lv  = letter_val(in_char);
  assign ovf = (cnt >= MaxCnt);

  always_comb begin
    mode_nxt = mode;
    nib_nxt  = nib;
    cnt_nxt  = cnt;
    res      = '0;
    do_emit  = 1'b0;
    emit_val = in_char;
    do_err   = 1'b0;
    err_st   = ST_OK;

    unique case (mode)
      MODE_DROP: begin
        if (in_fin) begin
          mode_nxt = MODE_IDLE;
          nib_nxt  = '0;
          cnt_nxt  = '0;
        end
      end
      MODE_SLASH: begin
        if (in_char == "x" || in_char == "X") begin
          if (in_fin) begin
            do_err = 1'b1;
            err_st = ST_TRUNC;
          end else begin
            mode_nxt = MODE_HEX1;
          end
        end else if (lv[8]) begin
          do_emit  = 1'b1;
          emit_val = lv[7:0];
        end else begin
          do_err = 1'b1;
          err_st = ST_UNKNOWN;
        end
      end
      MODE_HEX1: begin
        if (in_fin) begin
          do_err = 1'b1;
          err_st = ST_TRUNC;
        end else if (hv[4]) begin
          nib_nxt  = hv[3:0];
          mode_nxt = MODE_HEX2;
        end else begin
          do_err = 1'b1;
          err_st = ST_BADHEX;
        end
      end
      MODE_HEX2: begin
        if (hv[4]) begin
          do_emit  = 1'b1;
          emit_val = {nib, hv[3:0]};
        end else begin
          do_err = 1'b1;
          err_st = ST_BADHEX;
        end
      end
      default: begin
        if (in_char == CH_SLASH) begin
          if (in_fin) begin
            do_err = 1'b1;
            err_st = ST_TRAIL;
          end else begin
            mode_nxt = MODE_SLASH;
          end
        end else begin
          do_emit = 1'b1;
        end
      end
    endcase

    // a byte past the buffer size turns into an overflow error
    if (do_emit && ovf) begin
      do_emit = 1'b0;
      do_err  = 1'b1;
      err_st  = ST_OVERFLOW;
    end

    if (do_err) begin
      res.vld    = 1'b1;
      res.eos    = 1'b1;
      res.status = err_st;
      res.count  = (err_st == ST_OVERFLOW) ? MaxCnt : cnt;
      mode_nxt   = MODE_DROP;
    end else if (do_emit) begin
      res.vld      = 1'b1;
      res.data     = emit_val;
      res.has_byte = 1'b1;
      res.eos      = in_fin;
      res.count    = cnt + 1'b1;
      cnt_nxt      = cnt + 1'b1;
      mode_nxt     = MODE_IDLE;
    end

    // close the string
    if ((do_err || do_emit) && in_fin) begin
      mode_nxt = MODE_IDLE;
      nib_nxt  = '0;
      cnt_nxt  = '0;
    end
  end

endmodule

[src/slash_escape_decoder_top.sv]
// Path: input register, then decode (a single table step on it), then result register.
// Throughput: one character per cycle while the result register does not stall.
// A character ends in zero or one result; the result register stalls only on out_ready low.
// Reset (synchronous, rst_n low): both stages empty, escape mode idle, nibble and count zero.
module slash_escape_decoder_top #(
  parameter int MAX_LEN = 2048
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_char,
  input  logic                     in_is_final,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_byte,
  output logic                     out_has_byte,
  output logic                     out_end_of_string,
  output logic [2:0]               out_status,
  output logic [sed_pkg::CntW-1:0] out_byte_count
);
  import sed_pkg::*;

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_LEN);

  logic            s_vld_r;
  logic [7:0]      s_char_r;
  logic            s_fin_r;
  mode_t           mode_r, mode_nxt;
  logic [3:0]      nib_r, nib_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  res_t            res;
  res_t            o_r;
  logic            fire;

  // advance the input word when the result slot is free or draining
  assign fire     = s_vld_r && (!o_r.vld || out_ready);
  assign in_ready = !s_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (in_ready) begin
      s_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_char_r <= in_char;
      s_fin_r  <= in_is_final;
    end
  end

  sed_step #(
    .MAX_LEN(MAX_LEN)
  ) u_step (
    .mode     (mode_r),
    .nib      (nib_r),
    .cnt      (cnt_r),
    .in_char  (s_char_r),
    .in_fin   (s_fin_r),
    .mode_nxt (mode_nxt),
    .nib_nxt  (nib_nxt),
    .cnt_nxt  (cnt_nxt),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      nib_r  <= '0;
      cnt_r  <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      nib_r  <= nib_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_r <= '0;
    end else if (fire && res.vld) begin
      o_r <= res;
    end else if (out_ready) begin
      o_r.vld <= 1'b0;
    end
  end

  assign out_valid         = o_r.vld;
  assign out_byte          = o_r.data;
  assign out_has_byte      = o_r.has_byte;
  assign out_end_of_string = o_r.eos;
  assign out_status        = o_r.status;
  assign out_byte_count    = o_r.count;

`ifndef SYNTHESIS
  a_err_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_end_of_string && !out_has_byte)
    else $error("error result must close the string without a byte");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte_count <= MaxCnt)
    else $error("byte count past buffer size");

  a_byte_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_byte |-> out_byte_count != '0)
    else $error("decoded byte with zero count");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s_vld_r && !fire |=> s_vld_r && $stable(s_char_r) && $stable(s_fin_r))
    else $error("stalled input word lost");
`endif

endmodule
